// File: sv/utc_ts_pkg.sv
package utc_ts_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [4:0] POS_MAX = 5'd31;

    localparam logic [1:0] PHASE_FIXED    = 2'd0;
    localparam logic [1:0] PHASE_FRACTION = 2'd1;
    localparam logic [1:0] PHASE_SUFFIX   = 2'd2;

    localparam logic [2:0] SUFFIX_PLUS_DONE = 3'd6;
    localparam logic [2:0] SUFFIX_Z_DONE    = 3'd7;

    localparam logic [13:0] YEAR_MIN   = 14'd2023;
    localparam logic [13:0] YEAR_MAX   = 14'd2100;
    localparam logic [13:0] EPOCH_YEAR = 14'd1970;
    localparam logic [13:0] NO_LEAP_YEAR = 14'd2100;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        parse_ok;
    } fields_t;

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // days before the first of month m, non-leap year
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: sv/utc_ts_fifo.sv
module utc_ts_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  utc_ts_pkg::fields_t  wr_data,
    input  logic                 rd_en,
    output utc_ts_pkg::fields_t  rd_data,
    output logic                 full,
    output logic                 empty
);

    utc_ts_pkg::fields_t mem_reg [utc_ts_pkg::FIFO_DEPTH];
    logic [utc_ts_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [utc_ts_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [utc_ts_pkg::FIFO_AW:0]   count_reg, count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign full    = (count_reg == (utc_ts_pkg::FIFO_AW+1)'(utc_ts_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/utc_ts_parse.sv
module utc_ts_parse
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           character,
    input  logic                 last,
    output logic                 rec_wr,
    output utc_ts_pkg::fields_t  rec_data
);

    logic [4:0]  pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  sfx_reg, sfx_next;
    logic        frac_reg, frac_next;
    logic        bad_reg, bad_next;

    logic        is_digit;
    logic [3:0]  dval;

    function automatic logic [7:0] plus_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2B;
            3'd3:    c = 8'h3A;
            3'd1, 3'd2, 3'd4, 3'd5: c = 8'h30;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    assign is_digit = (character >= 8'h30) && (character <= 8'h39);
    assign dval     = 4'(character - 8'h30);

    always_comb
    begin
        pos_next    = pos_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        phase_next  = phase_reg;
        sfx_next    = sfx_reg;
        frac_next   = frac_reg;
        bad_next    = bad_reg;
        rec_wr      = 1'b0;
        rec_data    = '0;

        if (accept)
        begin
            // suffix handling is repeated inline in each phase
            case (phase_reg)
                utc_ts_pkg::PHASE_FIXED:
                begin
                    if (pos_reg == 5'd4 || pos_reg == 5'd7)
                    begin
                        if (character != 8'h2D) bad_next = 1'b1;
                    end
                    else if (pos_reg == 5'd10)
                    begin
                        if (character != 8'h54) bad_next = 1'b1;
                    end
                    else if (pos_reg == 5'd13 || pos_reg == 5'd16)
                    begin
                        if (character != 8'h3A) bad_next = 1'b1;
                    end
                    else if (pos_reg < 5'd19)
                    begin
                        if (!is_digit)
                        begin
                            bad_next = 1'b1;
                        end
                        else if (pos_reg < 5'd4)
                        begin
                            year_next = 14'(year_reg * 14'd10) + 14'(dval);
                        end
                        else if (pos_reg < 5'd7)
                        begin
                            month_next = 7'(month_reg * 7'd10) + 7'(dval);
                        end
                        else if (pos_reg < 5'd10)
                        begin
                            day_next = 7'(day_reg * 7'd10) + 7'(dval);
                        end
                        else if (pos_reg < 5'd13)
                        begin
                            hour_next = 7'(hour_reg * 7'd10) + 7'(dval);
                        end
                        else if (pos_reg < 5'd16)
                        begin
                            minute_next = 7'(minute_reg * 7'd10) + 7'(dval);
                        end
                        else
                        begin
                            second_next = 7'(second_reg * 7'd10) + 7'(dval);
                        end
                    end
                    else if (character == 8'h2E)
                    begin
                        phase_next = utc_ts_pkg::PHASE_FRACTION;
                        frac_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next = utc_ts_pkg::PHASE_SUFFIX;
                        if (sfx_reg == 3'd0 && character == 8'h5A)
                            sfx_next = utc_ts_pkg::SUFFIX_Z_DONE;
                        else if (sfx_reg < utc_ts_pkg::SUFFIX_PLUS_DONE
                                 && character == plus_char(sfx_reg))
                            sfx_next = sfx_reg + 3'd1;
                        else
                            bad_next = 1'b1;
                    end
                end
                utc_ts_pkg::PHASE_FRACTION:
                begin
                    if (is_digit)
                    begin
                        frac_next = 1'b1;
                    end
                    else if (!frac_reg)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = utc_ts_pkg::PHASE_SUFFIX;
                        if (sfx_reg == 3'd0 && character == 8'h5A)
                            sfx_next = utc_ts_pkg::SUFFIX_Z_DONE;
                        else if (sfx_reg < utc_ts_pkg::SUFFIX_PLUS_DONE
                                 && character == plus_char(sfx_reg))
                            sfx_next = sfx_reg + 3'd1;
                        else
                            bad_next = 1'b1;
                    end
                end
                utc_ts_pkg::PHASE_SUFFIX:
                begin
                    if (sfx_reg == utc_ts_pkg::SUFFIX_Z_DONE
                        || sfx_reg == utc_ts_pkg::SUFFIX_PLUS_DONE)
                        bad_next = 1'b1;
                    else if (sfx_reg == 3'd0 && character == 8'h5A)
                        sfx_next = utc_ts_pkg::SUFFIX_Z_DONE;
                    else if (character == plus_char(sfx_reg))
                        sfx_next = sfx_reg + 3'd1;
                    else
                        bad_next = 1'b1;
                end
                default:
                begin
                    bad_next = 1'b1;
                end
            endcase

            if (pos_reg < utc_ts_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 5'd1;
            end

            if (last)
            begin
                rec_wr            = 1'b1;
                rec_data.year     = year_next;
                rec_data.month    = month_next;
                rec_data.day      = day_next;
                rec_data.hour     = hour_next;
                rec_data.minute   = minute_next;
                rec_data.second   = second_next;
                rec_data.parse_ok = !bad_next
                                    && phase_next == utc_ts_pkg::PHASE_SUFFIX
                                    && (sfx_next == utc_ts_pkg::SUFFIX_Z_DONE
                                        || sfx_next == utc_ts_pkg::SUFFIX_PLUS_DONE);
                pos_next    = '0;
                year_next   = '0;
                month_next  = '0;
                day_next    = '0;
                hour_next   = '0;
                minute_next = '0;
                second_next = '0;
                phase_next  = utc_ts_pkg::PHASE_FIXED;
                sfx_next    = '0;
                frac_next   = 1'b0;
                bad_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            phase_reg  <= utc_ts_pkg::PHASE_FIXED;
            sfx_reg    <= '0;
            frac_reg   <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            phase_reg  <= phase_next;
            sfx_reg    <= sfx_next;
            frac_reg   <= frac_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

// File: sv/utc_ts_epoch.sv
module utc_ts_epoch
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  utc_ts_pkg::fields_t  rec_data,
    input  logic                 rec_empty,
    output logic                 rec_rd,
    input  logic                 pop,
    output logic                 empty,
    output logic [31:0]          epoch_seconds,
    output logic                 valid_res
);

    // stage 1: range checks, day count, seconds of day
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_ok_reg;
    logic [15:0] s1_days_reg;
    logic [16:0] s1_sod_reg;
    // stage 2: final epoch
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_ok_reg;
    logic [31:0] s2_epoch_reg;

    logic        s2_load;
    logic        s1_load;

    logic        leap;
    logic [3:0]  mon;
    logic [4:0]  dim;
    logic        ok;
    logic [13:0] yoff_full;
    logic [13:0] lcnt_full;
    logic [16:0] year_days;
    logic [15:0] days;
    logic [16:0] sod;
    logic [32:0] prod;

    assign mon       = rec_data.month[3:0];
    assign leap      = (rec_data.year[1:0] == 2'b00)
                       && (rec_data.year != utc_ts_pkg::NO_LEAP_YEAR);
    assign dim       = utc_ts_pkg::month_days(mon)
                       + 5'((rec_data.month == 7'd2) && leap);
    assign yoff_full = rec_data.year - utc_ts_pkg::EPOCH_YEAR;
    // leap years from 1970 up to the year before; exact for years through 2100
    assign lcnt_full = (yoff_full - 14'd1 + 14'd2) >> 2;
    assign year_days = 17'(yoff_full[7:0]) * 17'(utc_ts_pkg::DAYS_PER_YEAR);
    assign days      = 16'(year_days)
                       + 16'(lcnt_full[5:0])
                       + 16'(utc_ts_pkg::days_before_month(mon))
                       + 16'((rec_data.month > 7'd2) && leap)
                       + 16'(rec_data.day)
                       - 16'd1;
    assign sod       = 17'(17'(rec_data.hour[4:0]) * 17'(utc_ts_pkg::SECS_PER_HOUR))
                       + 17'(12'(rec_data.minute[5:0]) * 12'd60)
                       + 17'(rec_data.second);
    assign ok        = rec_data.parse_ok
                       && rec_data.year >= utc_ts_pkg::YEAR_MIN
                       && rec_data.year <= utc_ts_pkg::YEAR_MAX
                       && rec_data.month >= 7'd1 && rec_data.month <= 7'd12
                       && rec_data.hour <= 7'd23
                       && rec_data.minute <= 7'd59
                       && rec_data.second <= 7'd59
                       && rec_data.day >= 7'd1
                       && rec_data.day <= 7'(dim);

    assign prod    = 33'(s1_days_reg) * 33'(utc_ts_pkg::SECS_PER_DAY);

    assign s2_load = !s2_valid_reg || pop;
    assign s1_load = !s1_valid_reg || s2_load;
    assign rec_rd  = s1_load && !rec_empty;

    assign s1_valid_next = s1_load ? !rec_empty : s1_valid_reg;
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    assign empty         = !s2_valid_reg;
    assign epoch_seconds = s2_epoch_reg;
    assign valid_res     = s2_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_rd)
        begin
            s1_ok_reg   <= ok;
            s1_days_reg <= days;
            s1_sod_reg  <= sod;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_ok_reg    <= s1_ok_reg;
            s2_epoch_reg <= s1_ok_reg ? prod[31:0] + 32'(s1_sod_reg) : 32'd0;
        end
    end

endmodule

// File: sv/utc_timestamp_to_epoch.sv
// channel  | handshake         | payload
// ---------+-------------------+--------------------------------
// input    | push / full       | character[7:0], last
// result   | empty / pop       | epoch_seconds[31:0], valid_res
//
// One character per cycle while full is low; a text ending in last is written as a record
// to the record queue, then registered in the check stage and the multiply stage. Results
// then follow at one per cycle while pop is high. rst_n clears the parser and all queues.
// pop held low stalls the back end; full rises only when the record queue fills.
module utc_timestamp_to_epoch
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  character,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] epoch_seconds,
    output logic        valid_res
);

    utc_ts_pkg::fields_t wr_rec;
    utc_ts_pkg::fields_t rd_rec;
    logic                wr_en;
    logic                rd_en;
    logic                q_empty;
    logic                accept;

    assign accept = push && !full;

    utc_ts_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .character (character),
        .last      (last),
        .rec_wr    (wr_en),
        .rec_data  (wr_rec)
    );

    utc_ts_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_data (rd_rec),
        .full    (full),
        .empty   (q_empty)
    );

    utc_ts_epoch u_epoch
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_data      (rd_rec),
        .rec_empty     (q_empty),
        .rec_rd        (rd_en),
        .pop           (pop),
        .empty         (empty),
        .epoch_seconds (epoch_seconds),
        .valid_res     (valid_res)
    );

endmodule
